// ===== rtl/core/mss_pkg.sv =====
`timescale 1ns / 1ps

package mss_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  typedef logic [MOTOR_IDX_W-1:0] motor_idx_t;

  // Command codes carried on in_tuser
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  // Step counts that run without end
  localparam logic [15:0] STEPS_FWD = 16'h7FFF;
  localparam logic [15:0] STEPS_REV = 16'h8000;

  typedef struct packed {
    logic [7:0]  delay;
    logic [7:0]  timer;
    logic [15:0] steps;
    logic [1:0]  stage;
  } motor_state_t;

  typedef struct packed {
    logic delay;
    logic timer;
    logic steps;
    logic stage;
  } wr_mask_t;

  typedef struct packed {
    motor_state_t nxt;
    logic         wr;
    logic [7:0]   pat;
  } step_res_t;

  function automatic logic [7:0] coil_pattern(input logic [1:0] stage);
    logic [7:0] pat;
    case (stage)
      2'd0:    pat = 8'h99;
      2'd1:    pat = 8'h96;
      2'd2:    pat = 8'h66;
      default: pat = 8'h69;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/core/multi_stepper_stage_sequencer.sv =====
`timescale 1ns / 1ps

// Stepper sequencer for four motors, full-step coil patterns.
// Input channel in_*: one command per request. in_tuser is the opcode
// (tick, run, stop); in_tdata carries motor select, stage delay and signed
// step count. Run loads a motor's delay (zero taken as one) and step count
// and enables ticking; stop clears the step count. Neither gives a result.
// A tick, while ticking is enabled, visits the motors in order through one
// shared step unit, one motor per cycle while out_tready stays high, and
// gives one result per motor on out_*; out_tlast marks the final motor,
// whose result also carries all_idle. Run and stop are written to the
// register file as they are accepted; the tick rate is set by the single
// register file read port and step unit.
// in_tready is low while a tick is being worked. Each result sits in an
// output register; when the receiver stalls, the visit of the next motor
// holds until that register is taken. The last result may wait there while
// the next command is already accepted.
// Reset (rst_n low, synchronous) clears all motor state, disables ticking
// and empties the output register.
module multi_stepper_stage_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic [31:0] in_tdata,   // [1:0] motor_select, [9:2] stage_delay,
                                  // [25:10] step_count, [31:26] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] motor_id, [2] coil_write,
                                  // [10:3] coil_pattern, [11] all_idle,
                                  // [15:12] zero
  output logic        out_tlast   // last_of_tick
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_TICK = 1'b1;

  logic                  state_r, state_nxt;
  mss_pkg::motor_idx_t   idx_r, idx_nxt;
  logic                  busy_r, busy_nxt;
  logic                  tick_en_r, tick_en_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           out_data_r;
  logic                  out_last_r;

  logic [1:0]            in_op;
  logic [1:0]            in_sel;
  logic [7:0]            in_delay;
  logic [15:0]           in_steps;
  logic                  in_fire;
  logic                  sel_ok;
  logic                  out_free;
  logic                  visit;
  logic                  last_motor;

  mss_pkg::motor_idx_t   rd_idx;
  mss_pkg::motor_state_t rd_data;
  mss_pkg::motor_idx_t   wr_idx;
  mss_pkg::wr_mask_t     wr_en;
  mss_pkg::motor_state_t wr_data;
  mss_pkg::step_res_t    step;

  assign in_op    = in_tuser;
  assign in_sel   = in_tdata[1:0];
  assign in_delay = in_tdata[9:2];
  assign in_steps = in_tdata[25:10];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign sel_ok     = (int'(in_sel) < mss_pkg::MOTOR_COUNT);
  assign out_free   = !out_valid_r || out_tready;
  assign visit      = (state_r == S_TICK) && out_free;
  assign last_motor = (idx_r == mss_pkg::motor_idx_t'(mss_pkg::MOTOR_COUNT - 1));

  assign rd_idx = idx_r;

  mss_motor_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_idx  (wr_idx),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  mss_step_unit u_step (
    .cur (rd_data),
    .res (step)
  );

  // Register file write: commands write directly, a visit writes back the step.
  always_comb begin
    wr_idx        = idx_r;
    wr_en         = '0;
    wr_data       = step.nxt;
    if (visit) begin
      wr_en = '1;
    end else if (in_fire && sel_ok) begin
      wr_idx        = mss_pkg::motor_idx_t'(in_sel);
      wr_data.delay = (in_delay == 8'd0) ? 8'd1 : in_delay;
      wr_data.steps = (in_op == mss_pkg::OP_RUN) ? in_steps : 16'd0;
      if (in_op == mss_pkg::OP_RUN) begin
        wr_en.delay = 1'b1;
        wr_en.steps = 1'b1;
      end else if (in_op == mss_pkg::OP_STOP) begin
        wr_en.steps = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    tick_en_nxt   = tick_en_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == mss_pkg::OP_RUN && sel_ok) begin
            tick_en_nxt = 1'b1;
          end else if (in_op == mss_pkg::OP_TICK && tick_en_r) begin
            state_nxt = S_TICK;
            idx_nxt   = '0;
            busy_nxt  = 1'b0;
          end
        end
      end
      S_TICK: begin
        if (visit) begin
          out_valid_nxt = 1'b1;
          busy_nxt      = busy_r || (step.nxt.delay != 8'd0);
          if (last_motor) begin
            state_nxt = S_IDLE;
            if (!busy_nxt) begin
              tick_en_nxt = 1'b0;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      busy_r      <= 1'b0;
      tick_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      busy_r      <= busy_nxt;
      tick_en_r   <= tick_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output register on each visit; hold it otherwise.
  always_ff @(posedge clk) begin
    if (visit) begin
      out_data_r[1:0]   <= 2'(idx_r);
      out_data_r[2]     <= step.wr;
      out_data_r[10:3]  <= step.pat;
      out_data_r[11]    <= last_motor && !busy_nxt;
      out_data_r[15:12] <= 4'd0;
      out_last_r        <= last_motor;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/mss_motor_regs.sv =====
`timescale 1ns / 1ps

// Per-motor state: one read port, one masked write port.
module mss_motor_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mss_pkg::motor_idx_t   rd_idx,
  output mss_pkg::motor_state_t rd_data,
  input  mss_pkg::motor_idx_t   wr_idx,
  input  mss_pkg::wr_mask_t     wr_en,
  input  mss_pkg::motor_state_t wr_data
);

  mss_pkg::motor_state_t regs_r [mss_pkg::MOTOR_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < mss_pkg::MOTOR_COUNT; m++) begin
        regs_r[m] <= '0;
      end
    end else begin
      if (wr_en.delay) regs_r[wr_idx].delay <= wr_data.delay;
      if (wr_en.timer) regs_r[wr_idx].timer <= wr_data.timer;
      if (wr_en.steps) regs_r[wr_idx].steps <= wr_data.steps;
      if (wr_en.stage) regs_r[wr_idx].stage <= wr_data.stage;
    end
  end

  assign rd_data = regs_r[rd_idx];

endmodule

// ===== rtl/core/mss_step_unit.sv =====
`timescale 1ns / 1ps

// Shared step unit: advance one motor by one tick.
module mss_step_unit (
  input  mss_pkg::motor_state_t cur,
  output mss_pkg::step_res_t    res
);

  logic [7:0] tmr_dec;

  assign tmr_dec = cur.timer - 8'd1;

  always_comb begin
    res     = '0;
    res.nxt = cur;
    if (cur.delay != 8'd0) begin
      res.nxt.timer = tmr_dec;
      if (tmr_dec == 8'd0) begin
        res.wr = 1'b1;
        if (cur.steps == 16'd0) begin
          // out of steps: coils off, park the motor
          res.nxt.delay = 8'd0;
          res.nxt.stage = 2'd0;
        end else begin
          if (!cur.steps[15]) begin
            res.pat = mss_pkg::coil_pattern(cur.stage);
          end else begin
            res.pat = mss_pkg::coil_pattern(2'd3 - cur.stage);
          end
          if (cur.stage == 2'd3) begin
            res.nxt.stage = 2'd0;
            if (!cur.steps[15] && cur.steps != mss_pkg::STEPS_FWD) begin
              res.nxt.steps = cur.steps - 16'd1;
            end else if (cur.steps[15] && cur.steps != mss_pkg::STEPS_REV) begin
              res.nxt.steps = cur.steps + 16'd1;
            end
          end else begin
            res.nxt.stage = cur.stage + 2'd1;
          end
        end
        res.nxt.timer = res.nxt.delay;
      end
    end
  end

endmodule

// ===== rtl/core/mss_checker.sv =====
`timescale 1ns / 1ps

module mss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // No coil write means an all-off pattern byte.
  a_off_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[10:3] == 8'd0)
    else $error("pattern without coil write");

  // all_idle is only reported on the final motor of a tick.
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tlast)
    else $error("all_idle before last result");

  // While a tick is mid-way, no new command is taken.
  a_busy_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("command accepted during tick");

endmodule

bind multi_stepper_stage_sequencer mss_checker u_mss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
